### src/smie_pkg.sv
// package: opcodes, error codes, controller states and command structs for the stack machine core
package smie_pkg;

  localparam int STACK_DEPTH_DEF   = 256;
  localparam int MEMORY_WORDS_DEF  = 256;
  localparam int PROGRAM_WORDS_DEF = 4096;

  localparam int OPCODE_W = 5;
  localparam int WORD_W   = 32;
  localparam int ADDR_W   = 12;
  localparam int ERR_W    = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 5'd0, OP_POP = 5'd1, OP_DUP = 5'd2, OP_ADD = 5'd3, OP_SUB = 5'd4,
    OP_MUL = 5'd5, OP_DIV = 5'd6, OP_JMP = 5'd7, OP_JIT = 5'd8, OP_JIF = 5'd9,
    OP_CALL = 5'd10, OP_RET = 5'd11, OP_STS = 5'd12, OP_RCS = 5'd13,
    OP_EQ = 5'd14, OP_GT = 5'd15, OP_GE = 5'd16, OP_LT = 5'd17, OP_LE = 5'd18,
    OP_NE = 5'd19, OP_STO = 5'd20, OP_RCL = 5'd21, OP_END = 5'd22,
    OP_PRN = 5'd23, OP_STL = 5'd24, OP_RCE = 5'd25, OP_ALC = 5'd26,
    OP_FRE = 5'd27, OP_X28 = 5'd28, OP_X29 = 5'd29, OP_X30 = 5'd30, OP_X31 = 5'd31
  } opcode_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE = 3'd0, ERR_DUNDER = 3'd1, ERR_DOVER = 3'd2,
    ERR_CUNDER = 3'd3, ERR_COVER = 3'd4, ERR_DIVZERO = 3'd5
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_ALC, ST_FRE, ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item, start stack reads
    logic exec;       // evaluate and latch decode
    logic div_start;
    logic div_step;
    logic alc_step;
    logic commit;     // finish instruction, build result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stopped;
    logic fault;      // decode found error, end or limit
    logic need_div;
    logic need_alc;
    logic need_fre;
    logic div_done;
    logic alc_done;
  } stat_t;

endpackage

### src/smie_if.sv
// interfaces: valid/ready channels for instructions and results
interface smie_in_if;
  import smie_pkg::*;
  logic               valid;
  logic               ready;
  logic [OPCODE_W-1:0] opcode;
  logic signed [WORD_W-1:0] argument;
  modport source (output valid, opcode, argument, input ready);
  modport sink (input valid, opcode, argument, output ready);
endinterface

interface smie_out_if;
  import smie_pkg::*;
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  next_address;
  logic               print_valid;
  logic signed [WORD_W-1:0] print_value;
  logic               halted;
  logic [ERR_W-1:0]   error;
  modport source (output valid, next_address, print_valid, print_value, halted, error,
                  input ready);
  modport sink (input valid, next_address, print_valid, print_value, halted, error,
                output ready);
endinterface

### src/smie_ctrl.sv
// controller: sequences load, read, execute, iterative ops and result handoff
module smie_ctrl import smie_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!stat.fault && stat.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (!stat.fault && stat.need_alc) begin
          state_nxt = ST_ALC;
        end else if (!stat.fault && stat.need_fre) begin
          state_nxt = ST_FRE;
        end else begin
          cmd.commit = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          cmd.commit = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_ALC: begin
        cmd.alc_step = 1'b1;
        if (stat.alc_done) begin
          cmd.commit = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_FRE: begin
        cmd.commit   = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### src/smie_dp.sv
// datapath: stacks, data memory, alu, serial divider and machine registers
module smie_dp import smie_pkg::*; #(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int MEMORY_WORDS  = MEMORY_WORDS_DEF,
  parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [OPCODE_W-1:0]      in_opcode,
  input  logic [WORD_W-1:0]        in_argument,
  input  logic                     cfg_we,
  input  logic [WORD_W-1:0]        cfg_wdata,
  output logic [ADDR_W-1:0]        res_next_address,
  output logic                     res_print_valid,
  output logic [WORD_W-1:0]        res_print_value,
  output logic                     res_halted,
  output logic [ERR_W-1:0]         res_error
);

  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int MW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
  localparam int AW = (PROGRAM_WORDS > 1) ? $clog2(PROGRAM_WORDS) : 1;
  localparam logic [PW-1:0] DEPTH = PW'(STACK_DEPTH);

  logic [WORD_W-1:0] dstk [STACK_DEPTH];
  logic [WORD_W-1:0] cstk [STACK_DEPTH];
  logic [WORD_W-1:0] dmem [MEMORY_WORDS];

  logic [WORD_W-1:0] limit_r, steps_r;
  logic [AW-1:0]     pc_r, next_r;
  logic [PW-1:0]     dsp_r, csp_r, dsp_nxt_r, csp_nxt_r;
  logic              stopped_r;
  opcode_t           op_r;
  logic [WORD_W-1:0] arg_r;
  logic [WORD_W-1:0] t_r, s_r, cdepth_r, ctop_r, mrd_r;
  logic [ERR_W-1:0]  err_r;
  logic              fault_r;
  logic              ndiv_r, nalc_r, nfre_r;
  logic              dwe_r, cwe_r;
  logic [SW-1:0]     dwa_r, cwa_r;
  logic [WORD_W-1:0] dwd_r, cwd_r;
  logic              pv_r;
  logic [WORD_W-1:0] pval_r;
  logic [WORD_W-1:0] alc_cnt_r;
  logic [PW-1:0]     alc_ptr_r;
  logic [5:0]        div_cnt_r;
  logic [WORD_W-1:0] quo_r, rem_r, dvs_r;
  logic              dneg_r;

  // decode and evaluate signals
  logic [ERR_W-1:0]  err_w;
  logic              fault_w, ended_w, skip_w;
  logic [PW-1:0]     d_w, c_w;
  logic [AW-1:0]     next_w, inc_pc;
  logic              dwe_w, cwe_w, pv_w;
  logic [SW-1:0]     dwa_w, cwa_w;
  logic [WORD_W-1:0] dwd_w, cwd_w, res_w;
  logic signed [WORD_W-1:0] ss, ts, args;
  logic [WORD_W-1:0] prod;
  logic [AW-1:0]     jt;
  logic arg_ok_c, alc_ok;

  // stack and memory read addresses from the incoming item
  logic [SW-1:0] d1a, d2a, cta, cda;
  logic [PW-1:0] cidx;
  assign d1a  = SW'(dsp_r - PW'(1));
  assign d2a  = SW'(dsp_r - PW'(2));
  assign cta  = SW'(csp_r - PW'(1));
  assign cidx = csp_r - PW'(1) - PW'(in_argument);
  assign cda  = SW'(cidx);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= opcode_t'(in_opcode);
      arg_r    <= in_argument;
      t_r      <= dstk[d1a];
      s_r      <= dstk[d2a];
      ctop_r   <= cstk[cta];
      cdepth_r <= cstk[cda];
      mrd_r    <= dmem[MW'(in_argument % MEMORY_WORDS)];
    end
    if (dwe_r) dstk[dwa_r] <= dwd_r;
    if (cwe_r) cstk[cwa_r] <= cwd_r;
    if (cmd.exec && !fault_w && op_r == OP_STO)
      dmem[MW'(arg_r % MEMORY_WORDS)] <= t_r;
  end

  // decode and evaluate one instruction
  assign ss     = s_r;
  assign ts     = t_r;
  assign args   = arg_r;
  assign inc_pc = AW'((32'(pc_r) + 32'd1) % PROGRAM_WORDS);
  assign jt     = AW'(arg_r % PROGRAM_WORDS);
  assign prod   = s_r * t_r;
  assign arg_ok_c = !args[WORD_W-1] && (arg_r < 32'(csp_r));
  assign alc_ok   = !args[WORD_W-1] && (arg_r < 32'(DEPTH - csp_r));

  always_comb begin
    err_w  = ERR_NONE;
    ended_w = 1'b0;
    skip_w = stopped_r || (limit_r != '0 && steps_r >= limit_r);
    d_w = dsp_r;
    c_w = csp_r;
    next_w = inc_pc;
    dwe_w = 1'b0; dwa_w = SW'(dsp_r); dwd_w = arg_r;
    cwe_w = 1'b0; cwa_w = SW'(csp_r); cwd_w = arg_r;
    pv_w  = 1'b0;
    res_w = '0;
    case (op_r)
      OP_EQ: res_w = 32'(ss == ts);
      OP_GT: res_w = 32'(ss > ts);
      OP_GE: res_w = 32'(ss >= ts);
      OP_LT: res_w = 32'(ss < ts);
      OP_LE: res_w = 32'(ss <= ts);
      OP_NE: res_w = 32'(ss != ts);
      OP_ADD: res_w = s_r + t_r;
      OP_SUB: res_w = s_r - t_r;
      default: res_w = prod;
    endcase
    case (op_r)
      OP_PUSH: if (dsp_r >= DEPTH) err_w = ERR_DOVER;
               else begin dwe_w = 1'b1; d_w = dsp_r + PW'(1); end
      OP_POP: if (dsp_r < PW'(1)) err_w = ERR_DUNDER; else d_w = dsp_r - PW'(1);
      OP_DUP: if (dsp_r < PW'(1)) err_w = ERR_DUNDER;
              else if (dsp_r >= DEPTH) err_w = ERR_DOVER;
              else begin dwe_w = 1'b1; dwd_w = t_r; d_w = dsp_r + PW'(1); end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_GE, OP_LT, OP_LE, OP_NE: begin
        if (dsp_r < PW'(2)) err_w = ERR_DUNDER;
        else if (op_r == OP_DIV && t_r == '0) err_w = ERR_DIVZERO;
        else begin
          dwe_w = (op_r != OP_DIV); dwa_w = SW'(dsp_r - PW'(2)); dwd_w = res_w;
          d_w = dsp_r - PW'(1);
        end
      end
      OP_JMP: next_w = jt;
      OP_JIT, OP_JIF: if (dsp_r < PW'(1)) err_w = ERR_DUNDER;
        else begin
          d_w = dsp_r - PW'(1);
          if ((t_r != '0) == (op_r == OP_JIT)) next_w = jt;
        end
      OP_CALL: if (csp_r >= DEPTH) err_w = ERR_COVER;
        else begin cwe_w = 1'b1; cwd_w = 32'(pc_r); c_w = csp_r + PW'(1); next_w = jt; end
      OP_RET: if (csp_r < PW'(1)) err_w = ERR_CUNDER;
        else begin
          c_w = csp_r - PW'(1);
          next_w = AW'(((ctop_r % PROGRAM_WORDS) + 32'd1) % PROGRAM_WORDS);
        end
      OP_STO: if (dsp_r < PW'(1)) err_w = ERR_DUNDER; else d_w = dsp_r - PW'(1);
      OP_RCL: if (dsp_r >= DEPTH) err_w = ERR_DOVER;
              else begin dwe_w = 1'b1; dwd_w = mrd_r; d_w = dsp_r + PW'(1); end
      OP_END: ended_w = 1'b1;
      OP_PRN: if (dsp_r < PW'(1)) err_w = ERR_DUNDER;
              else begin pv_w = 1'b1; d_w = dsp_r - PW'(1); end
      OP_STL: if (dsp_r < PW'(1)) err_w = ERR_DUNDER;
        else if (!arg_ok_c) err_w = ERR_CUNDER;
        else begin cwe_w = 1'b1; cwa_w = SW'(csp_r - PW'(1) - PW'(arg_r)); cwd_w = t_r; end
      OP_RCE: if (!arg_ok_c) err_w = ERR_CUNDER;
        else if (dsp_r >= DEPTH) err_w = ERR_DOVER;
        else begin dwe_w = 1'b1; dwd_w = cdepth_r; d_w = dsp_r + PW'(1); end
      OP_ALC: if (!alc_ok) err_w = ERR_COVER;
              else c_w = csp_r + PW'(arg_r) + PW'(1);
      OP_FRE: if (csp_r < PW'(1)) err_w = ERR_CUNDER;
        else if (ctop_r[WORD_W-1] || ctop_r > 32'(csp_r - PW'(1))) err_w = ERR_CUNDER;
        else c_w = csp_r - PW'(ctop_r) - PW'(1);
      default: ;
    endcase
    fault_w = skip_w || (err_w != ERR_NONE) || ended_w;
  end

  logic [WORD_W-1:0] steps_inc;
  assign steps_inc = (steps_r == '1) ? steps_r : steps_r + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0; steps_r <= '0; pc_r <= '0; dsp_r <= '0; csp_r <= '0;
      stopped_r <= 1'b0; dwe_r <= 1'b0; cwe_r <= 1'b0;
      fault_r <= 1'b0; ndiv_r <= 1'b0; nalc_r <= 1'b0; nfre_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      dwe_r <= 1'b0;
      cwe_r <= 1'b0;
      if (cmd.exec) begin
        err_r   <= skip_w ? ERR_NONE : err_w;
        fault_r <= fault_w;
        dsp_nxt_r <= d_w; csp_nxt_r <= c_w; next_r <= next_w;
        pv_r    <= pv_w && !fault_w;
        pval_r  <= t_r;
        ndiv_r  <= (op_r == OP_DIV);
        nalc_r  <= (op_r == OP_ALC);
        nfre_r  <= (op_r == OP_FRE);
        alc_cnt_r <= arg_r;
        alc_ptr_r <= csp_r;
        dwe_r <= dwe_w && !fault_w; dwa_r <= dwa_w; dwd_r <= dwd_w;
        cwe_r <= cwe_w && !fault_w; cwa_r <= cwa_w; cwd_r <= cwd_w;
      end
      if (cmd.alc_step) begin
        cwe_r <= 1'b1;
        cwa_r <= SW'(alc_ptr_r);
        cwd_r <= (alc_cnt_r == '0) ? arg_r : '0;
        alc_ptr_r <= alc_ptr_r + PW'(1);
        alc_cnt_r <= alc_cnt_r - 32'd1;
      end
      if (cmd.div_step && div_cnt_r == 6'd0) begin
        dwe_r <= 1'b1;
        dwa_r <= SW'(dsp_r - PW'(2));
        dwd_r <= dneg_r ? (32'd0 - quo_r) : quo_r;
      end
      if (cmd.commit) begin
        if (fault_r) begin
          stopped_r <= 1'b1;
        end else begin
          dsp_r <= dsp_nxt_r; csp_r <= csp_nxt_r; pc_r <= next_r;
          steps_r <= steps_inc;
          if (limit_r != '0 && steps_inc >= limit_r) stopped_r <= 1'b1;
        end
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [WORD_W:0] trial;
  assign trial = {rem_r, quo_r[WORD_W-1]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r  <= s_r[WORD_W-1] ? (32'd0 - s_r) : s_r;
      dvs_r  <= t_r[WORD_W-1] ? (32'd0 - t_r) : t_r;
      rem_r  <= '0;
      dneg_r <= s_r[WORD_W-1] ^ t_r[WORD_W-1];
      div_cnt_r <= 6'(WORD_W);
    end else if (cmd.div_step && div_cnt_r != 6'd0) begin
      div_cnt_r <= div_cnt_r - 6'd1;
      if (!trial[WORD_W]) begin
        rem_r <= trial[WORD_W-1:0];
        quo_r <= {quo_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[WORD_W-2:0], quo_r[WORD_W-1]};
        quo_r <= {quo_r[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign stat.stopped  = stopped_r;
  assign stat.fault    = fault_r;
  assign stat.need_div = ndiv_r;
  assign stat.need_alc = nalc_r;
  assign stat.need_fre = nfre_r;
  assign stat.div_done = (div_cnt_r == 6'd0);
  assign stat.alc_done = (alc_cnt_r == '0);

  assign res_next_address = ADDR_W'(pc_r);
  assign res_print_valid  = pv_r;
  assign res_print_value  = pv_r ? pval_r : '0;
  assign res_halted       = stopped_r;
  assign res_error        = err_r;

endmodule

### src/stack_machine_instruction_executor_core.sv
// top level: stack machine core, controller plus datapath
//
//  channel | direction | transfer when     | payload
//  in      | sink      | in.valid&in.ready | opcode, argument
//  out     | source    | out.valid&ready   | next_address, print_valid, print_value, halted, error
//  cfg     | write     | cfg_we            | step_limit
//
// one instruction at a time; FRE takes an extra state, DIV runs the serial divider
// (one quotient bit per cycle plus write-back) and ALC fills the call stack (one call-stack
// write per cycle).
// the result register holds until taken; in.ready is high only when it is gone.
// rst_n is synchronous; stacks and data memory are not cleared.
module stack_machine_instruction_executor_core import smie_pkg::*; #(
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
  parameter int MEMORY_WORDS  = MEMORY_WORDS_DEF,
  parameter int PROGRAM_WORDS = PROGRAM_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  smie_in_if.sink           in_ch,
  smie_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  smie_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  smie_dp #(
    .STACK_DEPTH(STACK_DEPTH), .MEMORY_WORDS(MEMORY_WORDS), .PROGRAM_WORDS(PROGRAM_WORDS)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_opcode(in_ch.opcode), .in_argument(in_ch.argument),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .res_next_address(out_ch.next_address), .res_print_valid(out_ch.print_valid),
    .res_print_value(out_ch.print_value), .res_halted(out_ch.halted),
    .res_error(out_ch.error)
  );

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.error != ERR_NONE) |-> out_ch.halted)
    else $error("error without halt");
  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(stat.stopped) |-> stat.stopped) else $error("halt cleared");

endmodule
